// ----- rtl/core/pcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid package
// Shared widths, register indexes, reset values and record types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcbc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned MAG_W      = SUM_W - 1;
  localparam int unsigned STEP_W     = $clog2(MAG_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_W-1:0] MAX_POINTS = COUNT_W'(524288);

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_CEILING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd7;

  localparam logic signed [COORD_W-1:0] RST_BOX_MIN_X      = 16'sd1638;
  localparam logic signed [COORD_W-1:0] RST_BOX_MAX_X      = 16'sd3891;
  localparam logic signed [COORD_W-1:0] RST_BOX_MIN_Y      = -16'sd1024;
  localparam logic signed [COORD_W-1:0] RST_BOX_MAX_Y      = 16'sd1024;
  localparam logic signed [COORD_W-1:0] RST_HEIGHT_FLOOR   = 16'sd205;
  localparam logic signed [COORD_W-1:0] RST_HEIGHT_CEILING = 16'sd4096;
  localparam logic [COUNT_W-1:0]        RST_COUNT_THRESH   = 20'd270;
  localparam logic signed [SPEED_W-1:0] RST_MIN_SPEED      = 16'sd410;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] height_floor;
    logic signed [COORD_W-1:0] height_ceiling;
    logic [COUNT_W-1:0]        count_threshold;
    logic signed [SPEED_W-1:0] min_speed;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      count;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic                    above;
    logic                    risk;
  } rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_cloud_box_centroid_core.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid core
// Counts points inside a configured box per frame and reports the centroid.
// Points: one item per cycle; input stalls while the 2-deep frame queue is full.
// Result: zero centroid straight from idle when the count is at or below the threshold;
// otherwise a 35-step serial divider runs both axes in parallel; next frame starts after pop.
// Reset: clears sums, count, queues and restores register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_box_centroid_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pcbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pcbc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0]   point_x_i,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0]   point_y_i,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0]   point_z_i,
  input  wire logic                                 point_valid_i,
  input  wire logic                                 frame_last_i,
  input  wire logic signed [pcbc_pkg::SPEED_W-1:0]   linear_speed_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic                                      risk_flag_o,
  output logic signed [pcbc_pkg::COORD_W-1:0]        centroid_x_o,
  output logic signed [pcbc_pkg::COORD_W-1:0]        centroid_y_o,
  output logic [pcbc_pkg::COUNT_W-1:0]               points_in_box_o
);
  import pcbc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic accept;
  logic rec_push, rec_pop, rec_empty;
  rec_t rec_in, rec_out;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_MIN_X:      cfg_d.box_min_x       = cfg_data_i[COORD_W-1:0];
        REG_BOX_MAX_X:      cfg_d.box_max_x       = cfg_data_i[COORD_W-1:0];
        REG_BOX_MIN_Y:      cfg_d.box_min_y       = cfg_data_i[COORD_W-1:0];
        REG_BOX_MAX_Y:      cfg_d.box_max_y       = cfg_data_i[COORD_W-1:0];
        REG_HEIGHT_FLOOR:   cfg_d.height_floor    = cfg_data_i[COORD_W-1:0];
        REG_HEIGHT_CEILING: cfg_d.height_ceiling  = cfg_data_i[COORD_W-1:0];
        REG_COUNT_THRESH:   cfg_d.count_threshold = cfg_data_i[COUNT_W-1:0];
        REG_MIN_SPEED:      cfg_d.min_speed       = cfg_data_i[SPEED_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_min_x       <= RST_BOX_MIN_X;
      cfg_q.box_max_x       <= RST_BOX_MAX_X;
      cfg_q.box_min_y       <= RST_BOX_MIN_Y;
      cfg_q.box_max_y       <= RST_BOX_MAX_Y;
      cfg_q.height_floor    <= RST_HEIGHT_FLOOR;
      cfg_q.height_ceiling  <= RST_HEIGHT_CEILING;
      cfg_q.count_threshold <= RST_COUNT_THRESH;
      cfg_q.min_speed       <= RST_MIN_SPEED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic rec_full;

  assign full   = rec_full;
  assign accept = push && !rec_full;

  pcbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_valid_i  (point_valid_i),
    .frame_last_i   (frame_last_i),
    .linear_speed_i (linear_speed_i),
    .rec_push_o     (rec_push),
    .rec_o          (rec_in)
  );

  pcbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .pop_i   (rec_pop),
    .full_o  (rec_full),
    .empty_o (rec_empty),
    .data_o  (rec_out)
  );

  pcbc_div u_div (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_empty_i      (rec_empty),
    .rec_i            (rec_out),
    .rec_pop_o        (rec_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .risk_flag_o      (risk_flag_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .points_in_box_o  (points_in_box_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pcbc_front.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid front end
// Box test, saturating count and coordinate sums; emits one record per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbc_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pcbc_pkg::cfg_t                     cfg_i,
  input  wire logic                               accept_i,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0] point_y_i,
  input  wire logic signed [pcbc_pkg::COORD_W-1:0] point_z_i,
  input  wire logic                               point_valid_i,
  input  wire logic                               frame_last_i,
  input  wire logic signed [pcbc_pkg::SPEED_W-1:0] linear_speed_i,
  output logic                                    rec_push_o,
  output pcbc_pkg::rec_t                          rec_o
);
  import pcbc_pkg::*;

  logic [COUNT_W-1:0]      count_q, count_d, count_n;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_x_n;
  logic signed [SUM_W-1:0] sum_y_q, sum_y_d, sum_y_n;
  logic                    hit;
  logic                    above;

  always_comb begin
    hit = point_valid_i &&
          (point_x_i >= cfg_i.box_min_x) && (point_x_i <= cfg_i.box_max_x) &&
          (point_y_i >= cfg_i.box_min_y) && (point_y_i <= cfg_i.box_max_y) &&
          (point_z_i >= cfg_i.height_floor) && (point_z_i < cfg_i.height_ceiling) &&
          (count_q < MAX_POINTS);
    count_n = count_q;
    sum_x_n = sum_x_q;
    sum_y_n = sum_y_q;
    if (hit) begin
      count_n = count_q + COUNT_W'(1);
      sum_x_n = sum_x_q + SUM_W'(point_x_i);
      sum_y_n = sum_y_q + SUM_W'(point_y_i);
    end
    above = count_n > cfg_i.count_threshold;

    rec_push_o     = accept_i && frame_last_i;
    rec_o.count    = count_n;
    rec_o.sum_x    = sum_x_n;
    rec_o.sum_y    = sum_y_n;
    rec_o.above    = above;
    rec_o.risk     = above && (linear_speed_i >= cfg_i.min_speed);

    count_d = count_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    if (accept_i) begin
      if (frame_last_i) begin
        count_d = '0;
        sum_x_d = '0;
        sum_y_d = '0;
      end else begin
        count_d = count_n;
        sum_x_d = sum_x_n;
        sum_y_d = sum_y_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else begin
      count_q <= count_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcbc_fifo.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid frame queue
// Short queue of frame records between the front end and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pcbc_pkg::rec_t data_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output pcbc_pkg::rec_t      data_o
);
  import pcbc_pkg::*;

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  always_comb begin
    full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
    empty_o = cnt_q == '0;
    data_o  = mem_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcbc_div.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid back end
// Bit-serial signed division of both sums by the count; holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                rec_empty_i,
  input  wire pcbc_pkg::rec_t                      rec_i,
  output logic                                     rec_pop_o,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic                                     risk_flag_o,
  output logic signed [pcbc_pkg::COORD_W-1:0]      centroid_x_o,
  output logic signed [pcbc_pkg::COORD_W-1:0]      centroid_y_o,
  output logic [pcbc_pkg::COUNT_W-1:0]             points_in_box_o
);
  import pcbc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                st_q, st_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [COUNT_W-1:0]  div_q, div_d;
  logic [COUNT_W-1:0]  rem_q [2];
  logic [COUNT_W-1:0]  rem_d [2];
  logic [MAG_W-1:0]    dq_q [2];
  logic [MAG_W-1:0]    dq_d [2];
  logic                neg_q [2];
  logic                neg_d [2];
  logic [COUNT_W:0]    rem_sh [2];
  logic [COUNT_W-1:0]  rem_n [2];
  logic [MAG_W-1:0]    dq_n [2];
  logic [MAG_W-1:0]    q_s [2];
  logic signed [SUM_W-1:0] sum_in [2];
  logic [SUM_W-1:0]    mag_in [2];

  logic                out_valid_q, out_valid_d;
  logic                risk_q, risk_d;
  logic [COORD_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    sum_in[0] = rec_i.sum_x;
    sum_in[1] = rec_i.sum_y;
    for (int l = 0; l < 2; l++) begin
      mag_in[l] = sum_in[l][SUM_W-1] ? SUM_W'(-sum_in[l]) : SUM_W'(sum_in[l]);
      rem_sh[l] = {rem_q[l], dq_q[l][MAG_W-1]};
      if (rem_sh[l] >= {1'b0, div_q}) begin
        rem_n[l] = COUNT_W'(rem_sh[l] - {1'b0, div_q});
        dq_n[l]  = {dq_q[l][MAG_W-2:0], 1'b1};
      end else begin
        rem_n[l] = rem_sh[l][COUNT_W-1:0];
        dq_n[l]  = {dq_q[l][MAG_W-2:0], 1'b0};
      end
      q_s[l] = neg_q[l] ? (~dq_n[l] + MAG_W'(1)) : dq_n[l];
    end

    st_d        = st_q;
    step_d      = step_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    risk_d      = risk_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cnt_d       = cnt_q;
    rec_pop_o   = 1'b0;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (!rec_empty_i && !out_valid_q) begin
          rec_pop_o = 1'b1;
          risk_d    = rec_i.risk;
          cnt_d     = rec_i.count;
          div_d     = rec_i.count;
          step_d    = STEP_W'(MAG_W - 1);
          for (int l = 0; l < 2; l++) begin
            rem_d[l] = '0;
            dq_d[l]  = mag_in[l][MAG_W-1:0];
            neg_d[l] = sum_in[l][SUM_W-1];
          end
          if (rec_i.above) begin
            st_d = ST_DIV;
          end else begin
            cx_d        = '0;
            cy_d        = '0;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_d  = rem_n;
        dq_d   = dq_n;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          cx_d        = q_s[0][COORD_W-1:0];
          cy_d        = q_s[1][COORD_W-1:0];
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    neg_q  <= neg_d;
    risk_q <= risk_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o          = !out_valid_q;
  assign risk_flag_o      = risk_q;
  assign centroid_x_o     = cx_q;
  assign centroid_y_o     = cy_q;
  assign points_in_box_o  = cnt_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Point cloud box centroid testbench
// Streams points through the core and checks every frame report. Directed
// rows first cover the box bounds, truncation and the threshold cases, then
// random frames run under several register settings and idle patterns. An
// internal predictor tracks the count and the sums and computes the expected
// report of each frame for which no directed row gives its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcbc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      valid;
    logic                      last;
    logic signed [SPEED_W-1:0] speed;
  } point_t;

  typedef struct packed {
    logic                      risk;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [COUNT_W-1:0]        count;
  } frame_report_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    point_t                pt;
    logic                  typed;
    frame_report_t         want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  point_t                pin = '0;
  logic                  pin_typed = 1'b0;
  frame_report_t         pin_want = '0;
  logic                  risk_flag_o;
  logic signed [COORD_W-1:0] centroid_x_o;
  logic signed [COORD_W-1:0] centroid_y_o;
  logic [COUNT_W-1:0]    points_in_box_o;

  // predictor state
  cfg_t               mdl_cfg;
  logic [COUNT_W-1:0] mdl_count;
  longint             mdl_sum_x;
  longint             mdl_sum_y;
  frame_report_t      next_report;
  frame_report_t      got_want;

  frame_report_t frame_reports_q[$];
  int            reports_pending = 0;
  int            mismatch_cnt = 0;
  int            quiet_cycles = 0;
  int            tx_idle_pct = 15;
  int            rx_idle_pct = 57;
  int            rx_hold = 0;
  int            sent = 0;
  cfg_t          drv_cfg;
  dir_row_t      dir_tab[$];

  point_cloud_box_centroid_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .point_x_i        (pin.x),
    .point_y_i        (pin.y),
    .point_z_i        (pin.z),
    .point_valid_i    (pin.valid),
    .frame_last_i     (pin.last),
    .linear_speed_i   (pin.speed),
    .empty            (empty),
    .pop              (pop),
    .risk_flag_o      (risk_flag_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .points_in_box_o  (points_in_box_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit box_centroid_step(input point_t p, output frame_report_t r);
    logic   hit;
    logic   above;
    longint mean_x;
    longint mean_y;
    hit = p.valid && (p.x >= mdl_cfg.box_min_x) && (p.x <= mdl_cfg.box_max_x) &&
          (p.y >= mdl_cfg.box_min_y) && (p.y <= mdl_cfg.box_max_y) &&
          (p.z >= mdl_cfg.height_floor) && (p.z < mdl_cfg.height_ceiling) &&
          (mdl_count < MAX_POINTS);
    if (hit) begin
      mdl_count = mdl_count + 1'b1;
      mdl_sum_x += p.x;
      mdl_sum_y += p.y;
    end
    r = '0;
    if (!p.last) return 1'b0;
    above = mdl_count > mdl_cfg.count_threshold;
    mean_x = 0;
    mean_y = 0;
    if (above) begin
      mean_x = mdl_sum_x / longint'(mdl_count);
      mean_y = mdl_sum_y / longint'(mdl_count);
    end
    r.risk = above && (p.speed >= mdl_cfg.min_speed);
    r.cx = 16'(mean_x);
    r.cy = 16'(mean_y);
    r.count = mdl_count;
    mdl_count = '0;
    mdl_sum_x = 0;
    mdl_sum_y = 0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mdl_cfg = '{RST_BOX_MIN_X, RST_BOX_MAX_X, RST_BOX_MIN_Y, RST_BOX_MAX_Y,
                  RST_HEIGHT_FLOOR, RST_HEIGHT_CEILING, RST_COUNT_THRESH, RST_MIN_SPEED};
      mdl_count = '0;
      mdl_sum_x = 0;
      mdl_sum_y = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_BOX_MIN_X:      mdl_cfg.box_min_x = cfg_data[COORD_W-1:0];
          REG_BOX_MAX_X:      mdl_cfg.box_max_x = cfg_data[COORD_W-1:0];
          REG_BOX_MIN_Y:      mdl_cfg.box_min_y = cfg_data[COORD_W-1:0];
          REG_BOX_MAX_Y:      mdl_cfg.box_max_y = cfg_data[COORD_W-1:0];
          REG_HEIGHT_FLOOR:   mdl_cfg.height_floor = cfg_data[COORD_W-1:0];
          REG_HEIGHT_CEILING: mdl_cfg.height_ceiling = cfg_data[COORD_W-1:0];
          REG_COUNT_THRESH:   mdl_cfg.count_threshold = cfg_data[COUNT_W-1:0];
          REG_MIN_SPEED:      mdl_cfg.min_speed = cfg_data[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (box_centroid_step(pin, next_report)) begin
          frame_reports_q.insert(frame_reports_q.size(), pin_typed ? pin_want : next_report);
          reports_pending++;
        end
      end
      if (pop && !empty) begin
        if (frame_reports_q.size() == 0) begin
          $error("frame report with none expected: count %0d", points_in_box_o);
          mismatch_cnt++;
        end else begin
          got_want = frame_reports_q.pop_front();
          reports_pending--;
          if (risk_flag_o !== got_want.risk) begin
            $error("risk_flag expected %0d got %0d", got_want.risk, risk_flag_o);
            mismatch_cnt++;
          end
          if (centroid_x_o !== got_want.cx) begin
            $error("centroid_x expected %0d got %0d", got_want.cx, centroid_x_o);
            mismatch_cnt++;
          end
          if (centroid_y_o !== got_want.cy) begin
            $error("centroid_y expected %0d got %0d", got_want.cy, centroid_y_o);
            mismatch_cnt++;
          end
          if (points_in_box_o !== got_want.count) begin
            $error("points_in_box expected %0d got %0d", got_want.count, points_in_box_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // count cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic frame_report_t mk_report(input bit r, input int cx, input int cy,
                                              input int n);
    frame_report_t rep;
    rep.risk = r;
    rep.cx = 16'(cx);
    rep.cy = 16'(cy);
    rep.count = 20'(n);
    return rep;
  endfunction

  function automatic dir_row_t pt_row(input int x, input int y, input int z, input bit v,
                                      input bit l, input int s, input bit typed = 1'b0,
                                      input frame_report_t want = '0);
    dir_row_t row;
    row = '0;
    row.pt.x = 16'(x);
    row.pt.y = 16'(y);
    row.pt.z = 16'(z);
    row.pt.valid = v;
    row.pt.last = l;
    row.pt.speed = 16'(s);
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = 20'(data);
    return row;
  endfunction

  function automatic void add_row(input dir_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int bound_pick(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      default: return hi + 1;
    endcase
  endfunction

  function automatic point_t draw_point();
    point_t p;
    int     kind;
    int     sel;
    kind = $urandom_range(99);
    p.x = 16'($urandom);
    p.y = 16'($urandom);
    p.z = 16'($urandom);
    if (kind < 85) begin
      p.x = 16'(span(drv_cfg.box_min_x, drv_cfg.box_max_x));
      p.y = 16'(span(drv_cfg.box_min_y, drv_cfg.box_max_y));
      p.z = 16'(span(drv_cfg.height_floor, int'(drv_cfg.height_ceiling) - 1));
    end
    if (kind >= 70 && kind < 85) begin
      if ($urandom_range(1)) p.x = 16'(bound_pick(drv_cfg.box_min_x, drv_cfg.box_max_x));
      if ($urandom_range(1)) p.y = 16'(bound_pick(drv_cfg.box_min_y, drv_cfg.box_max_y));
      if ($urandom_range(1)) begin
        p.z = 16'(bound_pick(drv_cfg.height_floor, int'(drv_cfg.height_ceiling) - 1));
      end
    end
    p.valid = ($urandom_range(9) != 0);
    p.last = 1'b0;
    sel = $urandom_range(9);
    if (sel < 4) begin
      p.speed = drv_cfg.min_speed;
    end else if (sel == 4) begin
      p.speed = drv_cfg.min_speed - 1'b1;
    end else begin
      p.speed = 16'($urandom);
    end
    return p;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   mid;
    int   half;
    mid = int'($urandom_range(56000)) - 28000;
    half = 50 + int'($urandom_range(3000));
    c.box_min_x = 16'(mid - half);
    c.box_max_x = 16'(mid + half);
    mid = int'($urandom_range(56000)) - 28000;
    half = 50 + int'($urandom_range(3000));
    c.box_min_y = 16'(mid - half);
    c.box_max_y = 16'(mid + half);
    mid = int'($urandom_range(56000)) - 28000;
    c.height_floor = 16'(mid);
    c.height_ceiling = 16'(mid + 1 + int'($urandom_range(4000)));
    c.count_threshold = 20'($urandom_range(4));
    c.min_speed = 16'(int'($urandom_range(4000)) - 2000);
    return c;
  endfunction

  function automatic cfg_t wide_cfg(input logic [COUNT_W-1:0] thr,
                                    input logic signed [SPEED_W-1:0] spd);
    cfg_t c;
    c.box_min_x = 16'sh8000;
    c.box_max_x = 16'sh7fff;
    c.box_min_y = 16'sh8000;
    c.box_max_y = 16'sh7fff;
    c.height_floor = 16'sh8000;
    c.height_ceiling = 16'sh7fff;
    c.count_threshold = thr;
    c.min_speed = spd;
    return c;
  endfunction

  task automatic send_point(input point_t p, input bit typed, input frame_report_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pin <= p;
    pin_typed <= typed;
    pin_want <= want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_frame(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p = draw_point();
      p.last = (i == n - 1);
      send_point(p, 1'b0, '0);
    end
    sent += n;
  endtask

  task automatic run_frames(input int target);
    while (sent < target) begin
      send_frame(($urandom_range(19) == 0) ? 20 + int'($urandom_range(40))
                                           : 1 + int'($urandom_range(11)));
    end
  endtask

  // drain all reports, then let the divider go quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    wait (reports_pending == 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_t c);
    write_reg(REG_BOX_MIN_X, 20'(c.box_min_x));
    write_reg(REG_BOX_MAX_X, 20'(c.box_max_x));
    write_reg(REG_BOX_MIN_Y, 20'(c.box_min_y));
    write_reg(REG_BOX_MAX_Y, 20'(c.box_max_y));
    write_reg(REG_HEIGHT_FLOOR, 20'(c.height_floor));
    write_reg(REG_HEIGHT_CEILING, 20'(c.height_ceiling));
    write_reg(REG_COUNT_THRESH, c.count_threshold);
    write_reg(REG_MIN_SPEED, 20'(c.min_speed));
    cfg_we <= 1'b0;
    drv_cfg = c;
  endtask

  initial begin
    // reset register values: x [1638,3891], y [-1024,1024], z [205,4096)
    add_row(pt_row(2000, 0, 300, 0, 1, 0, 1, mk_report(0, 0, 0, 0)));
    add_row(pt_row(1638, -1024, 205, 1, 0, 0));
    add_row(pt_row(3891, 1024, 4095, 1, 0, 0));
    add_row(pt_row(2000, 0, 4096, 1, 0, 0));
    add_row(pt_row(1637, 0, 300, 1, 0, 0));
    add_row(pt_row(2000, 1025, 300, 1, 0, 0));
    add_row(pt_row(2000, 0, 204, 1, 0, 0));
    add_row(pt_row(-32768, -32768, -32768, 1, 1, 32767, 1, mk_report(0, 0, 0, 2)));
    add_row(pt_row(32767, 32767, 32767, 1, 1, -32768, 1, mk_report(0, 0, 0, 0)));
    add_row(cfg_row(REG_COUNT_THRESH, 0));
    add_row(pt_row(2000, -1000, 300, 1, 0, 0));
    add_row(pt_row(3000, 1001, 300, 1, 1, 410));
    add_row(pt_row(2000, -1000, 300, 1, 0, 0));
    add_row(pt_row(2001, -1001, 300, 1, 1, 409));
    add_row(pt_row(0, 0, 0, 1, 1, -1, 1, mk_report(0, 0, 0, 0)));
    add_row(cfg_row(REG_COUNT_THRESH, 524288));
    add_row(cfg_row(REG_BOX_MIN_X, 4000));
    add_row(pt_row(3950, 0, 300, 1, 1, 32767, 1, mk_report(0, 0, 0, 0)));
    add_row(cfg_row(REG_BOX_MIN_X, 1638));
    add_row(pt_row(2000, 0, 300, 0, 0, 0));
    add_row(pt_row(2000, 0, 300, 1, 1, 32767, 1, mk_report(0, 0, 0, 1)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
        cfg_we <= 1'b0;
      end else begin
        send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    settle();
    write_cfg(rand_cfg());
    run_frames(sent + 480);

    tx_idle_pct = 57;
    rx_idle_pct = 15;
    settle();
    write_cfg(wide_cfg('0, 16'sh8000));
    run_frames(sent + 480);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    write_cfg(rand_cfg());
    // hold the result side while short frames back up the core
    rx_hold = 400;
    repeat (40) send_frame(2);
    run_frames(sent + 160);
    push <= 1'b0;
    @(posedge clk_i);
    wait (reports_pending == 0);
    @(posedge clk_i);
    run_frames(sent + 230);

    push <= 1'b0;
    @(posedge clk_i);
    wait (reports_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
